[hw/rtl/gfpe_pkg.sv]
// Shared types and constants of the gray framebuffer pixel engine.
package gfpe_pkg;

  // Operation codes carried by an input item.
  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_DRAW = 2'd1,
    OP_GET  = 2'd2
  } op_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WEIGHT_RED   = 2'd0;
  localparam logic [1:0] CFG_WEIGHT_GREEN = 2'd1;
  localparam logic [1:0] CFG_WEIGHT_BLUE  = 2'd2;
  localparam logic [1:0] CFG_RB_SCALE     = 2'd3;

  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned LEVEL_MAX  = 15;

  localparam logic [9:0] WEIGHT_RED_RST   = 10'd77;
  localparam logic [9:0] WEIGHT_GREEN_RST = 10'd150;
  localparam logic [9:0] WEIGHT_BLUE_RST  = 10'd29;
  localparam logic [4:0] RB_SCALE_RST     = 5'd17;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;   // write zero at the clear pointer and advance it
    logic load;    // capture an accepted input item
    logic finish;  // commit the item and load the output register
  } gfpe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;  // clear pointer is at the last byte
  } gfpe_sts_t;

endpackage

[hw/rtl/gfpe_ctrl.sv]
// Controller state machine of the gray framebuffer pixel engine.
module gfpe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  gfpe_pkg::gfpe_sts_t sts,
  output gfpe_pkg::gfpe_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_FINISH
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  always_comb begin
    cmd.clear  = (state_r == ST_CLEAR);
    cmd.load   = (state_r == ST_IDLE) && in_valid;
    cmd.finish = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_CLEAR: begin
          if (sts.clear_last) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid) state_r <= ST_EXEC;
        end
        ST_EXEC: begin
          state_r <= ST_FINISH;
        end
        ST_FINISH: begin
          if (cmd.finish) state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_CLEAR;
        end
      endcase
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_rise_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result appeared without a finishing item");

  a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("finished item did not reach the output register");

  a_load_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_EXEC))
    else $error("accepted item did not start execution");

  a_no_load_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> !cmd.load && !cmd.finish)
    else $error("item activity during the clearing pass");

endmodule

[hw/rtl/gfpe_datapath.sv]
// Datapath of the gray framebuffer pixel engine: registers, pixel memory and arithmetic.
module gfpe_datapath #(
  parameter int WIDTH   = 128,
  parameter int HEIGHT  = 128,
  parameter int DIVISOR = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gfpe_pkg::gfpe_cmd_t         cmd,
  output gfpe_pkg::gfpe_sts_t         sts,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [gfpe_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]                  in_operation,
  input  logic [7:0]                  in_pos_x,
  input  logic [7:0]                  in_pos_y,
  input  logic [7:0]                  in_red_in,
  input  logic [7:0]                  in_green_in,
  input  logic [7:0]                  in_blue_in,
  output logic                        out_in_range,
  output logic [7:0]                  out_red_out,
  output logic [7:0]                  out_green_out,
  output logic [7:0]                  out_blue_out,
  output logic [3:0]                  out_level_now
);

  localparam int STORE_BYTES = (WIDTH * HEIGHT + 1) / 2;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

  // Configuration registers.
  logic [9:0] weight_red_r;
  logic [9:0] weight_green_r;
  logic [9:0] weight_blue_r;
  logic [4:0] rb_scale_r;

  // Item registers.
  gfpe_pkg::op_t     op_r;
  logic              ok_r;
  logic              high_r;
  logic [ADDR_W-1:0] addr_r;
  logic [7:0]        red_r;
  logic [7:0]        green_r;
  logic [7:0]        blue_r;
  logic [17:0]       prod_red_r;
  logic [17:0]       prod_green_r;
  logic [17:0]       prod_blue_r;
  logic [7:0]        rd_data_r;
  logic [3:0]        active_level_r;
  logic [ADDR_W-1:0] clr_cnt_r;

  logic [7:0] pixel_mem_r [STORE_BYTES];

  logic [7:0] out_chan_r;
  logic       out_in_range_r;
  logic [3:0] out_level_r;

  logic        x_ok;
  logic        y_ok;
  logic [15:0] pix_idx;
  logic [19:0] sum;
  logic [3:0]  level_nxt;
  logic [3:0]  rd_level;
  logic [8:0]  chan_wide;
  logic [7:0]  chan;
  logic [7:0]  wr_byte;
  logic        draw_wr;

  assign x_ok    = {1'b0, in_pos_x} < 9'(WIDTH);
  assign y_ok    = {1'b0, in_pos_y} < 9'(HEIGHT);
  assign pix_idx = 16'(in_pos_y) * 16'(WIDTH) + 16'(in_pos_x);

  assign sts.clear_last = (clr_cnt_r == ADDR_W'(STORE_BYTES - 1));

  // Level is the count of multiples of the divisor that the sum reaches, capped at 15.
  always_comb begin
    sum       = 20'(prod_red_r) + 20'(prod_green_r) + 20'(prod_blue_r);
    level_nxt = 4'd0;
    for (int k = 1; k <= int'(gfpe_pkg::LEVEL_MAX); k++) begin
      if (21'(sum) >= 21'(k * DIVISOR)) level_nxt = 4'(k);
    end
  end

  assign rd_level  = high_r ? rd_data_r[7:4] : rd_data_r[3:0];
  assign chan_wide = 9'(rd_level) * 9'(rb_scale_r);
  assign chan      = (chan_wide > 9'd255) ? 8'hFF : chan_wide[7:0];
  assign wr_byte   = high_r ? {active_level_r, rd_data_r[3:0]}
                            : {rd_data_r[7:4], active_level_r};
  assign draw_wr   = cmd.finish && (op_r == gfpe_pkg::OP_DRAW) && ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_red_r   <= gfpe_pkg::WEIGHT_RED_RST;
      weight_green_r <= gfpe_pkg::WEIGHT_GREEN_RST;
      weight_blue_r  <= gfpe_pkg::WEIGHT_BLUE_RST;
      rb_scale_r     <= gfpe_pkg::RB_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gfpe_pkg::CFG_WEIGHT_RED:   weight_red_r   <= cfg_data;
        gfpe_pkg::CFG_WEIGHT_GREEN: weight_green_r <= cfg_data;
        gfpe_pkg::CFG_WEIGHT_BLUE:  weight_blue_r  <= cfg_data;
        gfpe_pkg::CFG_RB_SCALE:     rb_scale_r     <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r      <= '0;
      active_level_r <= 4'd0;
    end else begin
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.finish && (op_r == gfpe_pkg::OP_SET)) active_level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= gfpe_pkg::op_t'(in_operation);
      ok_r    <= x_ok && y_ok;
      high_r  <= ~pix_idx[0];
      addr_r  <= pix_idx[ADDR_W:1];
      red_r   <= in_red_in;
      green_r <= in_green_in;
      blue_r  <= in_blue_in;
    end
    prod_red_r   <= 18'(red_r) * 18'(weight_red_r);
    prod_green_r <= 18'(green_r) * 18'(weight_green_r);
    prod_blue_r  <= 18'(blue_r) * 18'(weight_blue_r);
  end

  // Single-port pixel memory: clearing pass, draw write-back, registered read.
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      pixel_mem_r[clr_cnt_r] <= 8'h00;
    end else if (draw_wr) begin
      pixel_mem_r[addr_r] <= wr_byte;
    end
    rd_data_r <= pixel_mem_r[addr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      case (op_r)
        gfpe_pkg::OP_SET: begin
          out_in_range_r <= 1'b1;
          out_chan_r     <= 8'h00;
          out_level_r    <= level_nxt;
        end
        gfpe_pkg::OP_DRAW: begin
          out_in_range_r <= ok_r;
          out_chan_r     <= 8'h00;
          out_level_r    <= active_level_r;
        end
        gfpe_pkg::OP_GET: begin
          out_in_range_r <= ok_r;
          out_chan_r     <= ok_r ? chan : 8'h00;
          out_level_r    <= active_level_r;
        end
        default: begin
          out_in_range_r <= 1'b0;
          out_chan_r     <= 8'h00;
          out_level_r    <= active_level_r;
        end
      endcase
    end
  end

  assign out_in_range  = out_in_range_r;
  assign out_red_out   = out_chan_r;
  assign out_green_out = out_chan_r;
  assign out_blue_out  = out_chan_r;
  assign out_level_now = out_level_r;

endmodule

[hw/rtl/gray4_framebuffer_pixel_engine.sv]
// Top level of the gray framebuffer pixel engine.
//
// The block keeps a WIDTH x HEIGHT framebuffer of 4-bit gray pixels, two per
// byte with the even pixel in the high nibble. An input item carries an
// operation (set active color, draw pixel, get pixel), a position and a color.
// Every accepted item gives exactly one result item on the output channel.
// Both channels use valid and stall; an item moves at an edge with valid high
// and stall low. The configuration port writes the color weights and the
// readback scale; it may be written only while no item is in flight.
// An accepted item passes through capture, multiply and memory read, then
// commit with the memory write-back, where its result is loaded into the
// output register. A new item is taken only once the last one has committed;
// the single read-modify-write port of the pixel memory and the shared item
// registers make it so.
// The output register keeps the result while the receiver stalls; the engine
// still accepts a new item then, but holds the next commit until the register
// is free. After reset the pixel memory is cleared, one byte a cycle, over all
// (WIDTH*HEIGHT+1)/2 bytes (8192 at the default size); in_stall stays
// high for that whole pass, while configuration writes are taken as usual.
module gray4_framebuffer_pixel_engine #(
  parameter int WIDTH   = 128,
  parameter int HEIGHT  = 128,
  parameter int DIVISOR = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_pos_x,
  input  logic [7:0] in_pos_y,
  input  logic [7:0] in_red_in,
  input  logic [7:0] in_green_in,
  input  logic [7:0] in_blue_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_in_range,
  output logic [7:0] out_red_out,
  output logic [7:0] out_green_out,
  output logic [7:0] out_blue_out,
  output logic [3:0] out_level_now
);

  // Command and status signals between the controller and the datapath.
  gfpe_pkg::gfpe_cmd_t cmd;
  gfpe_pkg::gfpe_sts_t sts;

  // The controller sequences clearing, item capture, execution and commit.
  gfpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the registers, the pixel memory and the arithmetic.
  gfpe_datapath #(
    .WIDTH   (WIDTH),
    .HEIGHT  (HEIGHT),
    .DIVISOR (DIVISOR)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_operation  (in_operation),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .out_in_range  (out_in_range),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .out_level_now (out_level_now)
  );

endmodule

[dv/tb_top.sv]
// Self-checking testbench of the gray framebuffer pixel engine with a shadow framebuffer.
`timescale 1ns / 1ps

module tb_top;

  // Geometry and divisor of the engine under test, also used by the shadow copy.
  localparam int FB_WIDTH  = 128;
  localparam int FB_HEIGHT = 128;
  localparam int LEVEL_DIV = 4096;
  localparam int FB_BYTES  = (FB_WIDTH * FB_HEIGHT + 1) / 2;

  // The fourth operation code has no meaning; the engine must answer it with a neutral result.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Cycles without any handshake before the run is declared hung. The limit sits
  // well above the clearing pass after reset.
  localparam int STALL_LIMIT = 5 * FB_BYTES;

  // Idle cycles granted after the last result before registers change or the run ends.
  localparam int SETTLE_CYCLES = 4;

  // One result item as the engine reports it.
  typedef struct packed {
    logic       in_range;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [3:0] level;
  } pixel_result_t;

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       cfg_we        = 1'b0;
  logic [1:0] cfg_index     = gfpe_pkg::CFG_WEIGHT_RED;
  logic [9:0] cfg_data      = '0;
  logic       in_valid      = 1'b0;
  logic       in_stall;
  logic [1:0] in_operation  = gfpe_pkg::OP_SET;
  logic [7:0] in_pos_x      = '0;
  logic [7:0] in_pos_y      = '0;
  logic [7:0] in_red_in     = '0;
  logic [7:0] in_green_in   = '0;
  logic [7:0] in_blue_in    = '0;
  logic       out_valid;
  logic       out_stall     = 1'b0;
  logic       out_in_range;
  logic [7:0] out_red_out;
  logic [7:0] out_green_out;
  logic [7:0] out_blue_out;
  logic [3:0] out_level_now;

  // Shadow copy of the engine: framebuffer bytes, active level and registers.
  logic [7:0] fb_shadow [FB_BYTES];
  logic [3:0] shadow_level;
  logic [9:0] shadow_w_red;
  logic [9:0] shadow_w_green;
  logic [9:0] shadow_w_blue;
  logic [4:0] shadow_rb_scale;

  // Results predicted for accepted items, oldest first.
  pixel_result_t expected_pixels [$];

  // When set, neither the sender nor the receiver inserts idle cycles.
  logic quiet = 1'b0;

  int error_count     = 0;
  int results_checked = 0;
  int idle_cycles     = 0;
  int n_set           = 0;
  int n_draw          = 0;
  int n_get           = 0;
  int n_unused        = 0;
  int n_offscreen     = 0;
  int n_saturated     = 0;
  int n_settings      = 1;

  gray4_framebuffer_pixel_engine #(
    .WIDTH  (FB_WIDTH),
    .HEIGHT (FB_HEIGHT),
    .DIVISOR(LEVEL_DIV)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_red_in    (in_red_in),
    .in_green_in  (in_green_in),
    .in_blue_in   (in_blue_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_in_range (out_in_range),
    .out_red_out  (out_red_out),
    .out_green_out(out_green_out),
    .out_blue_out (out_blue_out),
    .out_level_now(out_level_now)
  );

  always #4 clk = ~clk;

  // Applies one accepted item to the shadow state and returns the result the
  // engine owes for it. Pixel p = y * width + x sits in byte p / 2, in the high
  // nibble when p is even.
  function automatic pixel_result_t apply_pixel_op(input logic [1:0] op,
                                                   input logic [7:0] x, y, r, g, b);
    pixel_result_t res;
    int unsigned   sum;
    int unsigned   lvl;
    int unsigned   chan;
    int unsigned   pix;
    int unsigned   addr;
    logic          on_screen;
    res       = '0;
    on_screen = (x < FB_WIDTH) && (y < FB_HEIGHT);
    pix       = y * FB_WIDTH + x;
    addr      = pix / 2;
    case (op)
      gfpe_pkg::OP_SET: begin
        sum = r * shadow_w_red + g * shadow_w_green + b * shadow_w_blue;
        lvl = sum / LEVEL_DIV;
        if (lvl > gfpe_pkg::LEVEL_MAX) begin
          lvl = gfpe_pkg::LEVEL_MAX;
        end
        shadow_level = lvl[3:0];
        res.in_range = 1'b1;
        n_set++;
      end
      gfpe_pkg::OP_DRAW: begin
        n_draw++;
        if (on_screen) begin
          if (pix[0]) begin
            fb_shadow[addr][3:0] = shadow_level;
          end else begin
            fb_shadow[addr][7:4] = shadow_level;
          end
          res.in_range = 1'b1;
        end else begin
          n_offscreen++;
        end
      end
      gfpe_pkg::OP_GET: begin
        n_get++;
        if (on_screen) begin
          lvl  = pix[0] ? fb_shadow[addr][3:0] : fb_shadow[addr][7:4];
          chan = lvl * shadow_rb_scale;
          // A level times a large scale does not fit a channel and saturates.
          if (chan > 255) begin
            chan = 255;
            n_saturated++;
          end
          res.in_range = 1'b1;
          res.red      = chan[7:0];
          res.green    = chan[7:0];
          res.blue     = chan[7:0];
        end else begin
          n_offscreen++;
        end
      end
      default: begin
        n_unused++;
      end
    endcase
    res.level = shadow_level;
    return res;
  endfunction

  // Offers one item, holds it until the engine takes it, and records the
  // result it must produce. Called at a falling edge, returns at one.
  task automatic send_item(input logic [1:0] op, input logic [7:0] x, y, r, g, b);
    while (!quiet && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_pos_x     <= x;
    in_pos_y     <= y;
    in_red_in    <= r;
    in_green_in  <= g;
    in_blue_in   <= b;
    do begin
      @(posedge clk);
    end while (in_stall);
    expected_pixels.push_back(apply_pixel_op(op, x, y, r, g, b));
    @(negedge clk);
  endtask

  // Stops offering items and waits until every predicted result has come out.
  task automatic drain;
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes all four registers, one per cycle, while the engine is idle.
  // Only the low five bits of the scale word are meant to be kept.
  task automatic load_config(input logic [9:0] w_red, w_green, w_blue, scale_word);
    cfg_we    <= 1'b1;
    cfg_index <= gfpe_pkg::CFG_WEIGHT_RED;
    cfg_data  <= w_red;
    @(negedge clk);
    cfg_index <= gfpe_pkg::CFG_WEIGHT_GREEN;
    cfg_data  <= w_green;
    @(negedge clk);
    cfg_index <= gfpe_pkg::CFG_WEIGHT_BLUE;
    cfg_data  <= w_blue;
    @(negedge clk);
    cfg_index <= gfpe_pkg::CFG_RB_SCALE;
    cfg_data  <= scale_word;
    @(negedge clk);
    cfg_we          <= 1'b0;
    shadow_w_red    = w_red;
    shadow_w_green  = w_green;
    shadow_w_blue   = w_blue;
    shadow_rb_scale = scale_word[4:0];
    n_settings++;
  endtask

  // Reset register values: full-white and mid colors, draws into both nibbles
  // of one byte, back-to-back draw and get of the same pixel, two screen
  // corners, off-screen positions on either axis, and the unused operation.
  task automatic test_default_levels;
    send_item(gfpe_pkg::OP_GET,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
    send_item(gfpe_pkg::OP_SET,  8'd0,   8'd0,   8'd255, 8'd255, 8'd255);
    send_item(gfpe_pkg::OP_DRAW, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
    send_item(gfpe_pkg::OP_DRAW, 8'd127, 8'd127, 8'd0,   8'd0,   8'd0);
    send_item(gfpe_pkg::OP_GET,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
    send_item(gfpe_pkg::OP_GET,  8'd127, 8'd127, 8'd0,   8'd0,   8'd0);
    send_item(gfpe_pkg::OP_GET,  8'd1,   8'd0,   8'd0,   8'd0,   8'd0);
    send_item(gfpe_pkg::OP_SET,  8'd0,   8'd0,   8'd100, 8'd50,  8'd200);
    send_item(gfpe_pkg::OP_DRAW, 8'd1,   8'd0,   8'd0,   8'd0,   8'd0);
    send_item(gfpe_pkg::OP_GET,  8'd1,   8'd0,   8'd0,   8'd0,   8'd0);
    send_item(gfpe_pkg::OP_GET,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
    send_item(gfpe_pkg::OP_DRAW, 8'd128, 8'd0,   8'd0,   8'd0,   8'd0);
    send_item(gfpe_pkg::OP_DRAW, 8'd0,   8'd128, 8'd0,   8'd0,   8'd0);
    send_item(gfpe_pkg::OP_GET,  8'd255, 8'd255, 8'd0,   8'd0,   8'd0);
    send_item(gfpe_pkg::OP_GET,  8'd127, 8'd128, 8'd0,   8'd0,   8'd0);
    send_item(OP_UNUSED,         8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    drain();
  endtask

  // Register extremes: the largest weights and a scale with the upper data
  // bits set, so that readback saturates; then every register at zero.
  task automatic test_register_extremes;
    load_config(10'd1023, 10'd1023, 10'd1023, 10'h3FF);
    send_item(gfpe_pkg::OP_SET,  8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
    send_item(gfpe_pkg::OP_DRAW, 8'd2, 8'd1, 8'd0,   8'd0,   8'd0);
    send_item(gfpe_pkg::OP_GET,  8'd2, 8'd1, 8'd0,   8'd0,   8'd0);
    send_item(gfpe_pkg::OP_SET,  8'd0, 8'd0, 8'd1,   8'd1,   8'd1);
    send_item(gfpe_pkg::OP_DRAW, 8'd3, 8'd1, 8'd0,   8'd0,   8'd0);
    send_item(gfpe_pkg::OP_SET,  8'd0, 8'd0, 8'd5,   8'd0,   8'd0);
    send_item(gfpe_pkg::OP_DRAW, 8'd3, 8'd1, 8'd0,   8'd0,   8'd0);
    send_item(gfpe_pkg::OP_GET,  8'd3, 8'd1, 8'd0,   8'd0,   8'd0);
    drain();
    load_config(10'd0, 10'd0, 10'd0, 10'd0);
    send_item(gfpe_pkg::OP_SET,  8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
    send_item(gfpe_pkg::OP_GET,  8'd2, 8'd1, 8'd0,   8'd0,   8'd0);
    drain();
  endtask

  // Random traffic. Most positions fall in a small corner window or near the
  // far corner so that gets often land on freshly drawn pixels; a tenth lie
  // off screen.
  task automatic run_random_items(input int count);
    logic [1:0] op;
    logic [7:0] x;
    logic [7:0] y;
    int         pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        op = gfpe_pkg::OP_SET;
      end else if (pick < 60) begin
        op = gfpe_pkg::OP_DRAW;
      end else if (pick < 95) begin
        op = gfpe_pkg::OP_GET;
      end else begin
        op = OP_UNUSED;
      end
      pick = $urandom_range(99);
      if (pick < 60) begin
        x = 8'($urandom_range(15));
        y = 8'($urandom_range(7));
      end else if (pick < 75) begin
        x = 8'($urandom_range(127, 120));
        y = 8'($urandom_range(127, 120));
      end else if (pick < 90) begin
        x = 8'($urandom_range(FB_WIDTH - 1));
        y = 8'($urandom_range(FB_HEIGHT - 1));
      end else begin
        x = 8'($urandom_range(255));
        y = 8'($urandom_range(255));
        if (x < FB_WIDTH && y < FB_HEIGHT) begin
          x[7] = 1'b1;
        end
      end
      send_item(op, x, y, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)));
    end
  endtask

  // Several register settings, each followed by a batch of random items.
  // The third batch runs with no idling on either side.
  task automatic test_random_traffic;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: load_config(gfpe_pkg::WEIGHT_RED_RST, gfpe_pkg::WEIGHT_GREEN_RST,
                       gfpe_pkg::WEIGHT_BLUE_RST, 10'(gfpe_pkg::RB_SCALE_RST));
        2: load_config(10'd1023, 10'd1023, 10'd1023, 10'd17);
        3: load_config(10'd0, 10'd1023, 10'd0, 10'd31);
        default: load_config(10'($urandom_range(1023)), 10'($urandom_range(1023)),
                             10'($urandom_range(1023)), 10'($urandom_range(1023)));
      endcase
      quiet = (phase == 2);
      run_random_items(400);
      drain();
      quiet = 1'b0;
    end
  endtask

  // Reports one field that differs from its prediction.
  task automatic check_field(input string name, input int unsigned want, got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Every result that leaves the engine is matched against the oldest prediction.
  always @(posedge clk) begin
    pixel_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t ns: result item with none expected, expected nothing, %s %b %0d %0d %0d %0d",
                 $time, "actual", out_in_range, out_red_out, out_green_out, out_blue_out,
                 out_level_now);
        error_count++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("in_range",  want.in_range, out_in_range);
        check_field("red_out",   want.red,      out_red_out);
        check_field("green_out", want.green,    out_green_out);
        check_field("blue_out",  want.blue,     out_blue_out);
        check_field("level_now", want.level,    out_level_now);
        results_checked++;
      end
    end
  end

  // The receiver stalls at random, except in the quiet stretch.
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 8);
  end

  // Hang detection: too many cycles in a row with no handshake on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("** gray4_framebuffer_pixel_engine: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    foreach (fb_shadow[i]) begin
      fb_shadow[i] = '0;
    end
    shadow_level    = '0;
    shadow_w_red    = gfpe_pkg::WEIGHT_RED_RST;
    shadow_w_green  = gfpe_pkg::WEIGHT_GREEN_RST;
    shadow_w_blue   = gfpe_pkg::WEIGHT_BLUE_RST;
    shadow_rb_scale = gfpe_pkg::RB_SCALE_RST;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_default_levels();
    test_register_extremes();
    test_random_traffic();

    in_valid <= 1'b0;
    repeat (2 * SETTLE_CYCLES) @(negedge clk);

    $display("Ran %0d items: %0d set color, %0d draw, %0d get, %0d unused operation.",
             n_set + n_draw + n_get + n_unused, n_set, n_draw, n_get, n_unused);
    $display("%0d results checked over %0d register settings; %0d off screen, %0d saturated.",
             results_checked, n_settings, n_offscreen, n_saturated);
    if (error_count == 0 && expected_pixels.size() == 0) begin
      $display("** gray4_framebuffer_pixel_engine: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results still outstanding", error_count,
               expected_pixels.size());
      $display("** gray4_framebuffer_pixel_engine: FAILED **");
    end
    $finish;
  end

endmodule
